@@ sv/arp_pkg.sv @@
// arp resolver package: table sizes, codes, entry and result types, helpers
// used by every module of the resolver; depends on nothing
package arp_pkg;

    localparam int MAP_ENTRIES = 16;
    localparam int REQ_ENTRIES = 16;
    localparam int WAIT_DEPTH  = 16;

    localparam int MAP_AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int REQ_AW = (REQ_ENTRIES > 1) ? $clog2(REQ_ENTRIES) : 1;
    localparam int WAIT_AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WCNT_W = $clog2(WAIT_DEPTH + 1);
    localparam int IDX_W = (MAP_AW > REQ_AW) ? ((MAP_AW > WAIT_AW) ? MAP_AW : WAIT_AW)
                                             : ((REQ_AW > WAIT_AW) ? REQ_AW : WAIT_AW);

    localparam int MAC_W = 48;
    localparam int IP_W  = 32;
    localparam int TAG_W = 16;
    localparam int AGE_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [MAC_W-1:0] MAC_BCAST = '1;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_ARP  = 16'h0806;
    localparam logic [15:0] ARP_OP_REQ = 16'd1;
    localparam logic [AGE_W-1:0] RETRY_RESET = AGE_W'(5 * 1000);
    localparam logic [AGE_W-1:0] LIFE_RESET  = AGE_W'(30 * 1000);

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFE    = 2'd3;

    localparam logic [1:0] MODE_SEND = 2'd0;
    localparam logic [1:0] MODE_RECV = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    typedef enum logic [2:0] {
        KIND_IPV4    = 3'd0,
        KIND_ARP_REQ = 3'd1,
        KIND_ARP_REP = 3'd2,
        KIND_DELIVER = 3'd3,
        KIND_DROP    = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [MAC_W-1:0] dst_mac;
        logic [TAG_W-1:0] tag;
        logic [IP_W-1:0]  tip;
        logic [MAC_W-1:0] tmac;
    } t_res;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic [AGE_W-1:0] age;
    } t_map_ent;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [AGE_W-1:0] age;
    } t_req_ent;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [TAG_W-1:0] tag;
    } t_wait_ent;

    typedef enum logic [14:0] {
        S_IDLE    = 15'h0001,
        S_MAP_RD  = 15'h0002,
        S_MAP_EV  = 15'h0004,
        S_MAP_WR  = 15'h0008,
        S_WAIT_RD = 15'h0010,
        S_WAIT_EV = 15'h0020,
        S_REPLY   = 15'h0040,
        S_REQ_RD  = 15'h0080,
        S_REQ_EV  = 15'h0100,
        S_REQ_WR  = 15'h0200,
        S_AREQ_RD = 15'h0400,
        S_AREQ_EV = 15'h0800,
        S_AMAP_RD = 15'h1000,
        S_AMAP_EV = 15'h2000,
        S_FLUSH   = 15'h4000
    } t_state;

    function automatic t_res mk_res(t_kind k, logic [MAC_W-1:0] dmac,
                                    logic [TAG_W-1:0] tag, logic [IP_W-1:0] tip,
                                    logic [MAC_W-1:0] tmac);
        t_res r;
        r.kind    = k;
        r.dst_mac = dmac;
        r.tag     = tag;
        r.tip     = tip;
        r.tmac    = tmac;
        return r;
    endfunction

    function automatic logic [AGE_W-1:0] age_add(logic [AGE_W-1:0] a,
                                                 logic [AGE_W-1:0] d);
        logic [AGE_W:0] s;
        s = {1'b0, a} + {1'b0, d};
        return s[AGE_W] ? '1 : s[AGE_W-1:0];
    endfunction

endpackage

@@ sv/arp_obuf.sv @@
// arp resolver output register: holds one result item until taken
// depends on arp_pkg for the result type
module arp_obuf (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic                    i_last,
    input  arp_pkg::t_res           i_res,
    output logic                    o_ready,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [2:0]              o_kind,
    output logic [arp_pkg::MAC_W-1:0] o_dst_mac,
    output logic [arp_pkg::TAG_W-1:0] o_out_tag,
    output logic [arp_pkg::IP_W-1:0]  o_arp_target_ip_out,
    output logic [arp_pkg::MAC_W-1:0] o_arp_target_mac_out,
    output logic                    o_last
);
    import arp_pkg::*;

    logic r_v;
    logic r_last;
    t_res r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_push) begin
            r_v <= 1'b1;
        end else if (!i_stall) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res  <= i_res;
            r_last <= i_last;
        end
    end

    assign o_ready              = !r_v || !i_stall;
    assign o_valid              = r_v;
    assign o_kind               = r_res.kind;
    assign o_dst_mac            = r_res.dst_mac;
    assign o_out_tag            = r_res.tag;
    assign o_arp_target_ip_out  = r_res.tip;
    assign o_arp_target_mac_out = r_res.tmac;
    assign o_last               = r_last;

endmodule

@@ sv/arp_resolver_with_pending_queue.sv @@
// arp resolver top level: sequencer over cache, request and pending memories
// depends on arp_pkg and arp_obuf
// one item at a time; each table entry visited is read, then evaluated; send walks
// the cache, then on a miss queues the item and walks the requests (drops it if full);
// arp receive walks the cache, then the pending queue; tick ages requests, then cache
// results leave through a one-item output register, so output stall lengthens an item
// reset clears valid bits, pending count and control registers at once; no clearing pass
module arp_resolver_with_pending_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [arp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [arp_pkg::MAC_W-1:0]         i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_mode,
    input  logic [arp_pkg::IP_W-1:0]          i_next_hop_ip,
    input  logic [arp_pkg::TAG_W-1:0]         i_dgram_tag,
    input  logic [arp_pkg::MAC_W-1:0]         i_frame_dst_mac,
    input  logic [15:0]                       i_ether_type,
    input  logic                              i_payload_ok,
    input  logic [15:0]                       i_arp_op,
    input  logic [arp_pkg::MAC_W-1:0]         i_arp_sender_mac,
    input  logic [arp_pkg::IP_W-1:0]          i_arp_sender_ip,
    input  logic [arp_pkg::IP_W-1:0]          i_arp_target_ip,
    input  logic [arp_pkg::AGE_W-1:0]         i_elapsed_ms,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [2:0]                        o_kind,
    output logic [arp_pkg::MAC_W-1:0]         o_dst_mac,
    output logic [arp_pkg::TAG_W-1:0]         o_out_tag,
    output logic [arp_pkg::IP_W-1:0]          o_arp_target_ip_out,
    output logic [arp_pkg::MAC_W-1:0]         o_arp_target_mac_out,
    output logic                              o_last
);
    import arp_pkg::*;

    // configuration
    logic [MAC_W-1:0] r_own_mac;
    logic [IP_W-1:0]  r_own_ip;
    logic [AGE_W-1:0] r_retry;
    logic [AGE_W-1:0] r_life;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= '0;
            r_own_ip  <= '0;
            r_retry   <= RETRY_RESET;
            r_life    <= LIFE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OWN_MAC: r_own_mac <= i_cfg_data;
                CFG_OWN_IP:  r_own_ip  <= i_cfg_data[IP_W-1:0];
                CFG_RETRY:   r_retry   <= i_cfg_data[AGE_W-1:0];
                CFG_LIFE:    r_life    <= i_cfg_data[AGE_W-1:0];
                default: ;
            endcase
        end
    end

    // control and item registers
    t_state r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [MAP_ENTRIES-1:0] r_map_v, n_map_v;
    logic [REQ_ENTRIES-1:0] r_req_v, n_req_v;
    logic [WCNT_W-1:0] r_wcnt, n_wcnt;
    logic [WCNT_W-1:0] r_w, n_w;
    logic r_hit_v, n_hit_v;
    logic [IDX_W-1:0] r_hit, n_hit;
    logic r_old_v, n_old_v;
    logic [IDX_W-1:0] r_old, n_old;
    logic [AGE_W-1:0] r_old_age, n_old_age;
    logic r_pend_v, n_pend_v;
    t_res r_pend, n_pend;
    logic [IP_W-1:0] r_ip, n_ip;
    logic [TAG_W-1:0] r_tag, n_tag;
    logic [MAC_W-1:0] r_mac, n_mac;
    logic r_reply, n_reply;
    logic r_send, n_send;
    logic [AGE_W-1:0] r_dlt, n_dlt;

    // memories
    t_map_ent  r_map_mem [MAP_ENTRIES];
    t_req_ent  r_req_mem [REQ_ENTRIES];
    t_wait_ent r_wait_mem [WAIT_DEPTH];
    t_map_ent  r_map_rd;
    t_req_ent  r_req_rd;
    t_wait_ent r_wait_rd;

    logic map_we, map_re, req_we, req_re, wait_we, wait_re;
    logic [MAP_AW-1:0] map_wa;
    logic [REQ_AW-1:0] req_wa;
    logic [WAIT_AW-1:0] wait_wa;
    t_map_ent map_wd;
    t_req_ent req_wd;
    t_wait_ent wait_wd;

    logic [MAP_AW-1:0] midx;
    logic [REQ_AW-1:0] ridx;
    logic [WAIT_AW-1:0] widx;

    assign midx = r_idx[MAP_AW-1:0];
    assign ridx = r_idx[REQ_AW-1:0];
    assign widx = r_idx[WAIT_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_wa] <= map_wd;
        end
        if (map_re) begin
            r_map_rd <= r_map_mem[midx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_we) begin
            r_req_mem[req_wa] <= req_wd;
        end
        if (req_re) begin
            r_req_rd <= r_req_mem[ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wait_we) begin
            r_wait_mem[wait_wa] <= wait_wd;
        end
        if (wait_re) begin
            r_wait_rd <= r_wait_mem[widx];
        end
    end

    // lowest free slots
    logic map_free_v, req_free_v;
    logic [MAP_AW-1:0] map_free;
    logic [REQ_AW-1:0] req_free;

    always_comb begin
        map_free_v = 1'b0;
        map_free   = '0;
        for (int i = MAP_ENTRIES - 1; i >= 0; i--) begin
            if (!r_map_v[i]) begin
                map_free_v = 1'b1;
                map_free   = MAP_AW'(i);
            end
        end
    end

    always_comb begin
        req_free_v = 1'b0;
        req_free   = '0;
        for (int i = REQ_ENTRIES - 1; i >= 0; i--) begin
            if (!r_req_v[i]) begin
                req_free_v = 1'b1;
                req_free   = REQ_AW'(i);
            end
        end
    end

    // output stage
    logic obuf_rdy, push, push_last;

    arp_obuf u_obuf (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_push               (push),
        .i_last               (push_last),
        .i_res                (r_pend),
        .o_ready              (obuf_rdy),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_kind               (o_kind),
        .o_dst_mac            (o_dst_mac),
        .o_out_tag            (o_out_tag),
        .o_arp_target_ip_out  (o_arp_target_ip_out),
        .o_arp_target_mac_out (o_arp_target_mac_out),
        .o_last               (o_last)
    );

    assign o_stall = (r_state != S_IDLE);

    logic can_emit;
    logic hit;
    logic adv;
    logic last_ent;
    logic [AGE_W-1:0] aged;
    logic [MAP_AW-1:0] map_slot;
    logic [REQ_AW-1:0] req_slot;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_map_v   = r_map_v;
        n_req_v   = r_req_v;
        n_wcnt    = r_wcnt;
        n_w       = r_w;
        n_hit_v   = r_hit_v;
        n_hit     = r_hit;
        n_old_v   = r_old_v;
        n_old     = r_old;
        n_old_age = r_old_age;
        n_pend_v  = r_pend_v;
        n_pend    = r_pend;
        n_ip      = r_ip;
        n_tag     = r_tag;
        n_mac     = r_mac;
        n_reply   = r_reply;
        n_send    = r_send;
        n_dlt     = r_dlt;
        map_we    = 1'b0;
        map_re    = 1'b0;
        req_we    = 1'b0;
        req_re    = 1'b0;
        wait_we   = 1'b0;
        wait_re   = 1'b0;
        map_wa    = midx;
        req_wa    = ridx;
        wait_wa   = r_w[WAIT_AW-1:0];
        map_wd    = r_map_rd;
        req_wd    = r_req_rd;
        wait_wd   = r_wait_rd;
        push      = 1'b0;
        push_last = 1'b0;
        can_emit  = !r_pend_v || obuf_rdy;
        hit       = 1'b0;
        adv       = 1'b0;
        last_ent  = 1'b0;
        aged      = '0;
        map_slot  = '0;
        req_slot  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_ip    = (i_mode == MODE_SEND) ? i_next_hop_ip : i_arp_sender_ip;
                    n_tag   = i_dgram_tag;
                    n_mac   = i_arp_sender_mac;
                    n_reply = (i_arp_op == ARP_OP_REQ) && (i_arp_target_ip == r_own_ip);
                    n_dlt   = i_elapsed_ms;
                    n_idx   = '0;
                    n_hit_v = 1'b0;
                    n_old_v = 1'b0;
                    n_send  = (i_mode == MODE_SEND);
                    case (i_mode)
                        MODE_SEND: n_state = S_MAP_RD;
                        MODE_RECV: begin
                            if (i_frame_dst_mac == r_own_mac || i_frame_dst_mac == MAC_BCAST) begin
                                if (i_ether_type == ETH_IPV4) begin
                                    if (i_payload_ok) begin
                                        n_pend_v = 1'b1;
                                        n_pend   = mk_res(KIND_DELIVER, '0, '0, '0, '0);
                                        n_state  = S_FLUSH;
                                    end
                                end else if (i_ether_type == ETH_ARP && i_payload_ok) begin
                                    n_state = S_MAP_RD;
                                end
                            end
                        end
                        MODE_TICK: n_state = S_AREQ_RD;
                        default: ;
                    endcase
                end
            end

            S_MAP_RD: begin
                map_re  = 1'b1;
                n_state = S_MAP_EV;
            end

            S_MAP_EV: begin
                hit      = r_map_v[midx] && (r_map_rd.ip == r_ip);
                last_ent = (midx == MAP_AW'(MAP_ENTRIES - 1));
                if (r_send) begin
                    if (hit) begin
                        n_pend_v = 1'b1;
                        n_pend   = mk_res(KIND_IPV4, r_map_rd.mac, r_tag, '0, '0);
                        n_state  = S_FLUSH;
                    end else if (last_ent) begin
                        if (r_wcnt == WCNT_W'(WAIT_DEPTH)) begin
                            n_pend_v = 1'b1;
                            n_pend   = mk_res(KIND_DROP, '0, r_tag, '0, '0);
                            n_state  = S_FLUSH;
                        end else begin
                            wait_we    = 1'b1;
                            wait_wa    = r_wcnt[WAIT_AW-1:0];
                            wait_wd.ip = r_ip;
                            wait_wd.tag = r_tag;
                            n_wcnt     = r_wcnt + 1'b1;
                            n_idx      = '0;
                            n_state    = S_REQ_RD;
                        end
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_MAP_RD;
                    end
                end else begin
                    if (hit) begin
                        n_hit_v = 1'b1;
                        n_hit   = r_idx;
                        n_state = S_MAP_WR;
                    end else begin
                        if (r_map_v[midx] && (!r_old_v || r_map_rd.age > r_old_age)) begin
                            n_old_v   = 1'b1;
                            n_old     = r_idx;
                            n_old_age = r_map_rd.age;
                        end
                        if (last_ent) begin
                            n_state = S_MAP_WR;
                        end else begin
                            n_idx   = r_idx + 1'b1;
                            n_state = S_MAP_RD;
                        end
                    end
                end
            end

            S_MAP_WR: begin
                if (r_hit_v) begin
                    map_slot = r_hit[MAP_AW-1:0];
                end else if (map_free_v) begin
                    map_slot = map_free;
                end else begin
                    map_slot = r_old[MAP_AW-1:0];
                end
                map_we     = 1'b1;
                map_wa     = map_slot;
                map_wd.ip  = r_ip;
                map_wd.mac = r_mac;
                map_wd.age = '0;
                n_map_v[map_slot] = 1'b1;
                n_idx   = '0;
                n_w     = '0;
                n_state = (r_wcnt == '0) ? S_REPLY : S_WAIT_RD;
            end

            S_WAIT_RD: begin
                wait_re = 1'b1;
                n_state = S_WAIT_EV;
            end

            S_WAIT_EV: begin
                if (r_wait_rd.ip == r_ip) begin
                    if (can_emit) begin
                        push     = r_pend_v;
                        n_pend_v = 1'b1;
                        n_pend   = mk_res(KIND_IPV4, r_mac, r_wait_rd.tag, '0, '0);
                        adv      = 1'b1;
                    end
                end else begin
                    wait_we = 1'b1;
                    wait_wa = r_w[WAIT_AW-1:0];
                    wait_wd = r_wait_rd;
                    n_w     = r_w + 1'b1;
                    adv     = 1'b1;
                end
                if (adv) begin
                    if ((WCNT_W'(r_idx) + 1'b1) == r_wcnt) begin
                        n_wcnt  = n_w;
                        n_state = S_REPLY;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_WAIT_RD;
                    end
                end
            end

            S_REPLY: begin
                if (r_reply) begin
                    if (can_emit) begin
                        push     = r_pend_v;
                        n_pend_v = 1'b1;
                        n_pend   = mk_res(KIND_ARP_REP, r_mac, '0, r_ip, r_mac);
                        n_state  = S_FLUSH;
                    end
                end else begin
                    n_state = S_FLUSH;
                end
            end

            S_REQ_RD: begin
                req_re  = 1'b1;
                n_state = S_REQ_EV;
            end

            S_REQ_EV: begin
                hit      = r_req_v[ridx] && (r_req_rd.ip == r_ip);
                last_ent = (ridx == REQ_AW'(REQ_ENTRIES - 1));
                if (hit) begin
                    if (r_req_rd.age <= r_retry) begin
                        n_state = S_IDLE;
                    end else begin
                        n_hit_v = 1'b1;
                        n_hit   = r_idx;
                        n_state = S_REQ_WR;
                    end
                end else begin
                    if (r_req_v[ridx] && (!r_old_v || r_req_rd.age > r_old_age)) begin
                        n_old_v   = 1'b1;
                        n_old     = r_idx;
                        n_old_age = r_req_rd.age;
                    end
                    if (last_ent) begin
                        n_state = S_REQ_WR;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_REQ_RD;
                    end
                end
            end

            S_REQ_WR: begin
                if (r_hit_v) begin
                    req_slot = r_hit[REQ_AW-1:0];
                end else if (req_free_v) begin
                    req_slot = req_free;
                end else begin
                    req_slot = r_old[REQ_AW-1:0];
                end
                req_we     = 1'b1;
                req_wa     = req_slot;
                req_wd.ip  = r_ip;
                req_wd.age = '0;
                n_req_v[req_slot] = 1'b1;
                n_pend_v = 1'b1;
                n_pend   = mk_res(KIND_ARP_REQ, MAC_BCAST, '0, r_ip, '0);
                n_state  = S_FLUSH;
            end

            S_AREQ_RD: begin
                req_re  = 1'b1;
                n_state = S_AREQ_EV;
            end

            S_AREQ_EV: begin
                aged = age_add(r_req_rd.age, r_dlt);
                if (r_req_v[ridx]) begin
                    req_we     = 1'b1;
                    req_wd.age = aged;
                    if (aged > r_retry) begin
                        n_req_v[ridx] = 1'b0;
                    end
                end
                if (ridx == REQ_AW'(REQ_ENTRIES - 1)) begin
                    n_idx   = '0;
                    n_state = S_AMAP_RD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_AREQ_RD;
                end
            end

            S_AMAP_RD: begin
                map_re  = 1'b1;
                n_state = S_AMAP_EV;
            end

            S_AMAP_EV: begin
                aged = age_add(r_map_rd.age, r_dlt);
                if (r_map_v[midx]) begin
                    map_we     = 1'b1;
                    map_wd.age = aged;
                    if (aged >= r_life) begin
                        n_map_v[midx] = 1'b0;
                    end
                end
                if (midx == MAP_AW'(MAP_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_AMAP_RD;
                end
            end

            S_FLUSH: begin
                if (r_pend_v) begin
                    if (obuf_rdy) begin
                        push      = 1'b1;
                        push_last = 1'b1;
                        n_pend_v  = 1'b0;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_map_v  <= '0;
            r_req_v  <= '0;
            r_wcnt   <= '0;
            r_w      <= '0;
            r_hit_v  <= 1'b0;
            r_old_v  <= 1'b0;
            r_pend_v <= 1'b0;
            r_reply  <= 1'b0;
            r_send   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_map_v  <= n_map_v;
            r_req_v  <= n_req_v;
            r_wcnt   <= n_wcnt;
            r_w      <= n_w;
            r_hit_v  <= n_hit_v;
            r_old_v  <= n_old_v;
            r_pend_v <= n_pend_v;
            r_reply  <= n_reply;
            r_send   <= n_send;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit     <= n_hit;
        r_old     <= n_old;
        r_old_age <= n_old_age;
        r_pend    <= n_pend;
        r_ip      <= n_ip;
        r_tag     <= n_tag;
        r_mac     <= n_mac;
        r_dlt     <= n_dlt;
    end

endmodule
